>>> hdl/lbm_pkg.sv
// ============================================================================
// lbm_pkg: shared types and constants for the Lorentz boost pipeline
// Holds the fixed-point formats, stage counts and saturation bounds.
// ============================================================================
package lbm_pkg;

    // Result width and binary point of the Q formats.
    localparam int VAL_W     = 32;
    localparam int FRAC_BITS = 16;

    // Pipeline partitioning.
    localparam int FRONT_STAGES = 3;
    localparam int SQRT_STAGES  = 16;
    localparam int SQRT_STEPS   = 2;
    localparam int BACK_STAGES  = 8;
    localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + BACK_STAGES;

    // 1.0 in Q.F and in Q.2F.
    localparam logic [31:0] ONE_Q  = 32'd1 << FRAC_BITS;
    localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC_BITS);

    // Saturation bounds of a result component, held at the adder width.
    localparam logic signed [54:0] SAT_MAX = (55'sd1 <<< (VAL_W - 1)) - 55'sd1;
    localparam logic signed [54:0] SAT_MIN = -(55'sd1 <<< (VAL_W - 1));

    typedef logic [30:0]        ufix_t;
    typedef logic signed [17:0] dir_t;
    typedef logic signed [31:0] mom_t;
    typedef logic signed [50:0] dot_t;

    typedef struct packed {
        ufix_t            sinh;
        logic [2:0][17:0] dir;
        logic [2:0][31:0] mom;
    } pass_t;

    typedef struct packed {
        pass_t base;
        dot_t  dot;
    } side_t;

endpackage

>>> hdl/lbm_front.sv
// ============================================================================
// lbm_front: squares and projection of the incoming particle
// Three stages: products, partial sums, final sums of both radicands and p.n.
// ============================================================================
module lbm_front (
    input  logic                                aclk,
    input  logic [lbm_pkg::FRONT_STAGES-1:0]    en,
    input  lbm_pkg::ufix_t                      sinh,
    input  lbm_pkg::ufix_t                      mass,
    input  lbm_pkg::dir_t                       dir_x,
    input  lbm_pkg::dir_t                       dir_y,
    input  lbm_pkg::dir_t                       dir_z,
    input  lbm_pkg::mom_t                       mom_x,
    input  lbm_pkg::mom_t                       mom_y,
    input  lbm_pkg::mom_t                       mom_z,
    output logic [63:0]                         rad_c,
    output logic [63:0]                         rad_e,
    output lbm_pkg::side_t                      side
);
    import lbm_pkg::*;

    mom_t              mom_in [3];
    dir_t              dir_in [3];
    logic signed [63:0] sq     [3];
    logic signed [49:0] dp     [3];

    logic [61:0]        ss_reg;
    logic [61:0]        mm_reg;
    logic [62:0]        pp_reg [3];
    logic signed [49:0] dp_reg [3];
    pass_t              p0_reg;

    logic [62:0]        sa_reg;
    logic [63:0]        sb_reg;
    logic [62:0]        rc1_reg;
    logic signed [50:0] d01_reg;
    logic signed [49:0] d2_reg;
    pass_t              p1_reg;

    logic [63:0]        rad_c_reg;
    logic [63:0]        rad_e_reg;
    side_t              side_reg;

    assign mom_in[0] = mom_x;
    assign mom_in[1] = mom_y;
    assign mom_in[2] = mom_z;
    assign dir_in[0] = dir_x;
    assign dir_in[1] = dir_y;
    assign dir_in[2] = dir_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq[i] = mom_in[i] * mom_in[i];
            dp[i] = mom_in[i] * dir_in[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            ss_reg <= sinh * sinh;
            mm_reg <= mass * mass;
            for (int i = 0; i < 3; i++) begin
                pp_reg[i] <= sq[i][62:0];
                dp_reg[i] <= dp[i];
            end
            p0_reg.sinh <= sinh;
            p0_reg.dir  <= {dir_z, dir_y, dir_x};
            p0_reg.mom  <= {mom_z, mom_y, mom_x};
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sa_reg  <= {1'b0, mm_reg} + pp_reg[0];
            sb_reg  <= {1'b0, pp_reg[1]} + {1'b0, pp_reg[2]};
            rc1_reg <= {1'b0, ss_reg} + ONE_SQ[62:0];
            d01_reg <= 51'(dp_reg[0]) + 51'(dp_reg[1]);
            d2_reg  <= dp_reg[2];
            p1_reg  <= p0_reg;
        end
    end

    // The energy radicand stays below 2^64 for every input pattern.
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            rad_e_reg     <= {1'b0, sa_reg} + sb_reg;
            rad_c_reg     <= {1'b0, rc1_reg};
            side_reg.base <= p1_reg;
            side_reg.dot  <= d01_reg + 51'(d2_reg);
        end
    end

    assign rad_c = rad_c_reg;
    assign rad_e = rad_e_reg;
    assign side  = side_reg;

endmodule

>>> hdl/lbm_isqrt.sv
// ============================================================================
// lbm_isqrt: pipelined integer square root of a 64-bit radicand
// Restoring digit recurrence, two root bits per stage, floor result.
// ============================================================================
module lbm_isqrt (
    input  logic                               aclk,
    input  logic [lbm_pkg::SQRT_STAGES-1:0]    en,
    input  logic [63:0]                        rad_in,
    output logic [31:0]                        root
);
    import lbm_pkg::*;

    // One root bit: bring down two radicand bits and try to subtract 4q+1.
    function automatic logic [65:0] sq_step(input logic [33:0] rem,
                                            input logic [31:0] q,
                                            input logic [1:0]  pair);
        logic [35:0] rs;
        logic [35:0] t;
        logic [65:0] res;
        rs = {rem, pair};
        t  = {2'b00, q, 2'b01};
        if (rs >= t) begin
            rs  = rs - t;
            res = {rs[33:0], q[30:0], 1'b1};
        end else begin
            res = {rs[33:0], q[30:0], 1'b0};
        end
        sq_step = res;
    endfunction

    logic [63:0] rad_w [SQRT_STAGES];
    logic [33:0] rem_w [SQRT_STAGES];
    logic [31:0] q_w   [SQRT_STAGES + 1];

    assign rad_w[0] = rad_in;
    assign rem_w[0] = '0;
    assign q_w[0]   = '0;

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [65:0] s_a;
        logic [65:0] s_b;

        assign s_a = sq_step(rem_w[k], q_w[k], rad_w[k][63:62]);
        assign s_b = sq_step(s_a[65:32], s_a[31:0], rad_w[k][61:60]);

        if (k < SQRT_STAGES - 1) begin : g_mid
            logic [63:0] rad_reg;
            logic [33:0] rem_reg;
            logic [31:0] q_reg;

            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    rad_reg <= rad_w[k] << (2 * SQRT_STEPS);
                    rem_reg <= s_b[65:32];
                    q_reg   <= s_b[31:0];
                end
            end

            assign rad_w[k + 1] = rad_reg;
            assign rem_w[k + 1] = rem_reg;
            assign q_w[k + 1]   = q_reg;
        end else begin : g_last
            logic [31:0] q_reg;

            always_ff @(posedge aclk) begin
                if (en[k]) begin
                    q_reg <= s_b[31:0];
                end
            end

            assign q_w[k + 1] = q_reg;
        end
    end

    assign root = q_w[SQRT_STAGES];

endmodule

>>> hdl/lbm_back.sv
// ============================================================================
// lbm_back: boost factor and boosted momentum
// Forms f = E*s + (p.n)(cosh-1), then p + n*f with saturation, in 8 stages.
// ============================================================================
module lbm_back (
    input  logic                               aclk,
    input  logic [lbm_pkg::BACK_STAGES-1:0]    en,
    input  logic [31:0]                        cosh_q,
    input  logic [31:0]                        e_q,
    input  lbm_pkg::side_t                     side,
    output lbm_pkg::mom_t                      out_x,
    output lbm_pkg::mom_t                      out_y,
    output lbm_pkg::mom_t                      out_z,
    output logic                               saturated
);
    import lbm_pkg::*;

    // Stage 0
    logic [62:0]        t1_reg;
    logic [31:0]        cm1_reg;
    logic [50:0]        dmag_reg;
    logic               dneg0_reg;
    logic [2:0][17:0]   dir0_reg;
    logic [2:0][31:0]   mom0_reg;
    // Stage 1
    logic [63:0]        plo_reg;
    logic [50:0]        phi_reg;
    logic [62:0]        t1b_reg;
    logic               dneg1_reg;
    logic [2:0][17:0]   dir1_reg;
    logic [2:0][31:0]   mom1_reg;
    // Stage 2
    logic [50:0]        t2_reg;
    logic [46:0]        t1q_reg;
    logic               dneg2_reg;
    logic [2:0][17:0]   dir2_reg;
    logic [2:0][31:0]   mom2_reg;
    // Stage 3
    logic signed [51:0] f_reg;
    logic [2:0][17:0]   dir3_reg;
    logic [2:0][31:0]   mom3_reg;
    // Stage 4
    logic [50:0]        fmag_reg;
    logic [2:0][17:0]   nmag_reg;
    logic [2:0]         neg4_reg;
    logic [2:0][31:0]   mom4_reg;
    // Stage 5
    logic [2:0][49:0]   mlo_reg;
    logic [2:0][36:0]   mhi_reg;
    logic [2:0]         neg5_reg;
    logic [2:0][31:0]   mom5_reg;
    // Stage 6
    logic [2:0][52:0]   mag_reg;
    logic [2:0]         neg6_reg;
    logic [2:0][31:0]   mom6_reg;
    // Stage 7
    logic [2:0][31:0]   out_reg;
    logic               sat_reg;

    logic signed [51:0] t2s;
    logic [68:0]        psum [3];
    logic signed [54:0] vsum [3];
    logic signed [54:0] mterm [3];
    logic [2:0]         hi_clip;
    logic [2:0]         lo_clip;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t1_reg    <= e_q * side.base.sinh;
            cm1_reg   <= cosh_q - ONE_Q;
            dmag_reg  <= side.dot[50] ? 51'(-side.dot) : 51'(side.dot);
            dneg0_reg <= side.dot[50];
            dir0_reg  <= side.base.dir;
            mom0_reg  <= side.base.mom;
        end
    end

    // The projection magnitude is split at bit 32 so that no product is wider
    // than 32 by 32.
    always_ff @(posedge aclk) begin
        if (en[1]) begin
            plo_reg   <= dmag_reg[31:0] * cm1_reg;
            phi_reg   <= dmag_reg[50:32] * cm1_reg;
            t1b_reg   <= t1_reg;
            dneg1_reg <= dneg0_reg;
            dir1_reg  <= dir0_reg;
            mom1_reg  <= mom0_reg;
        end
    end

    // Shifting the Q.3F product by 2F drops exactly the low partial's low word.
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            t2_reg    <= phi_reg + 51'(plo_reg[63:32]);
            t1q_reg   <= t1b_reg[62:FRAC_BITS];
            dneg2_reg <= dneg1_reg;
            dir2_reg  <= dir1_reg;
            mom2_reg  <= mom1_reg;
        end
    end

    assign t2s = $signed({1'b0, t2_reg});

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            f_reg    <= $signed({5'b0, t1q_reg}) + (dneg2_reg ? -t2s : t2s);
            dir3_reg <= dir2_reg;
            mom3_reg <= mom2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            fmag_reg <= f_reg[51] ? 51'(-f_reg) : 51'(f_reg);
            for (int i = 0; i < 3; i++) begin
                nmag_reg[i] <= dir3_reg[i][17] ? 18'(-dir3_reg[i]) : dir3_reg[i];
                neg4_reg[i] <= dir3_reg[i][17] ^ f_reg[51];
            end
            mom4_reg <= mom3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                mlo_reg[i] <= nmag_reg[i] * fmag_reg[31:0];
                mhi_reg[i] <= nmag_reg[i] * fmag_reg[50:32];
            end
            neg5_reg <= neg4_reg;
            mom5_reg <= mom4_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            psum[i] = {mhi_reg[i], 32'b0} + 69'(mlo_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= psum[i][68:FRAC_BITS];
            end
            neg6_reg <= neg5_reg;
            mom6_reg <= mom5_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mterm[i]   = $signed({2'b0, mag_reg[i]});
            vsum[i]    = 55'($signed(mom6_reg[i])) + (neg6_reg[i] ? -mterm[i] : mterm[i]);
            hi_clip[i] = vsum[i] > SAT_MAX;
            lo_clip[i] = vsum[i] < SAT_MIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            for (int i = 0; i < 3; i++) begin
                if (hi_clip[i]) begin
                    out_reg[i] <= SAT_MAX[31:0];
                end else if (lo_clip[i]) begin
                    out_reg[i] <= SAT_MIN[31:0];
                end else begin
                    out_reg[i] <= vsum[i][31:0];
                end
            end
            sat_reg <= |(hi_clip | lo_clip);
        end
    end

    assign out_x     = $signed(out_reg[0]);
    assign out_y     = $signed(out_reg[1]);
    assign out_z     = $signed(out_reg[2]);
    assign saturated = sat_reg;

endmodule

>>> hdl/lorentz_boost_momentum_top.sv
// Throughput: one beat per cycle while m_ready is high; each pipeline stage
// advances when it is empty or when the stage after it advances, so bubbles are
// squeezed out during stalls. Most of the depth lies in the two 16-stage square
// root units, two root bits a stage.
// Reset (aresetn low, synchronous) empties the pipeline; no result is lost later.
// ============================================================================
// lorentz_boost_momentum_top: streaming Lorentz boost of particle momenta
// Computes cosh and energy by square root, then p + n*(E*sinh + (p.n)(cosh-1)),
// saturating each component to the signed 32-bit Q15.16 range.
// ============================================================================
module lorentz_boost_momentum_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lbm_pkg::ufix_t s_boost_sinh,
    input  lbm_pkg::dir_t  s_dir_x,
    input  lbm_pkg::dir_t  s_dir_y,
    input  lbm_pkg::dir_t  s_dir_z,
    input  lbm_pkg::ufix_t s_mass,
    input  lbm_pkg::mom_t  s_mom_x,
    input  lbm_pkg::mom_t  s_mom_y,
    input  lbm_pkg::mom_t  s_mom_z,
    output logic           m_valid,
    input  logic           m_ready,
    output lbm_pkg::mom_t  m_out_x,
    output lbm_pkg::mom_t  m_out_y,
    output lbm_pkg::mom_t  m_out_z,
    output logic           m_saturated
);
    import lbm_pkg::*;

    // One valid bit per stage travels alongside the data. The stage enables
    // form a ready chain that runs from the output register back to s_ready.
    logic [PIPE_DEPTH-1:0] v_reg;
    logic [PIPE_DEPTH-1:0] en;

    logic [63:0] rad_c;
    logic [63:0] rad_e;
    logic [31:0] cosh_q;
    logic [31:0] e_q;
    side_t       side_w;

    // Sideband data (sinh, direction, momentum, p.n) waits beside the square
    // root units, one register per root stage.
    side_t       dly_reg [SQRT_STAGES];

    always_comb begin
        en[PIPE_DEPTH-1] = !v_reg[PIPE_DEPTH-1] || m_ready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k + 1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k - 1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[PIPE_DEPTH-1];

    lbm_front u_front (
        .aclk  (aclk),
        .en    (en[FRONT_STAGES-1:0]),
        .sinh  (s_boost_sinh),
        .mass  (s_mass),
        .dir_x (s_dir_x),
        .dir_y (s_dir_y),
        .dir_z (s_dir_z),
        .mom_x (s_mom_x),
        .mom_y (s_mom_y),
        .mom_z (s_mom_z),
        .rad_c (rad_c),
        .rad_e (rad_e),
        .side  (side_w)
    );

    // cosh = sqrt(s^2 + 1) in Q.F.
    lbm_isqrt u_sqrt_cosh (
        .aclk   (aclk),
        .en     (en[FRONT_STAGES+SQRT_STAGES-1:FRONT_STAGES]),
        .rad_in (rad_c),
        .root   (cosh_q)
    );

    // E = sqrt(M^2 + |p|^2) in Q.F.
    lbm_isqrt u_sqrt_energy (
        .aclk   (aclk),
        .en     (en[FRONT_STAGES+SQRT_STAGES-1:FRONT_STAGES]),
        .rad_in (rad_e),
        .root   (e_q)
    );

    always_ff @(posedge aclk) begin
        if (en[FRONT_STAGES]) begin
            dly_reg[0] <= side_w;
        end
        for (int k = 1; k < SQRT_STAGES; k++) begin
            if (en[FRONT_STAGES + k]) begin
                dly_reg[k] <= dly_reg[k - 1];
            end
        end
    end

    lbm_back u_back (
        .aclk      (aclk),
        .en        (en[PIPE_DEPTH-1:FRONT_STAGES+SQRT_STAGES]),
        .cosh_q    (cosh_q),
        .e_q       (e_q),
        .side      (dly_reg[SQRT_STAGES-1]),
        .out_x     (m_out_x),
        .out_y     (m_out_y),
        .out_z     (m_out_z),
        .saturated (m_saturated)
    );

`ifndef ASSERT_OFF
    // A pipeline with at least one empty stage must be able to take a beat.
    a_bubble_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !(&v_reg) |-> s_ready)
        else $error("pipeline has a bubble but refuses input");

    // An accepted beat lands in the first stage.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v_reg[0])
        else $error("accepted beat did not enter the pipeline");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A clipped result has at least one component at a bound.
    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_saturated) |->
        (m_out_x == 32'sh7fffffff || m_out_x == 32'sh80000000 ||
         m_out_y == 32'sh7fffffff || m_out_y == 32'sh80000000 ||
         m_out_z == 32'sh7fffffff || m_out_z == 32'sh80000000))
        else $error("saturated flag without a clipped component");
`endif

endmodule
